// File: hdl/bcu_pkg.sv
// Shared constants and types for the binomial coefficient unit.
package bcu_pkg;

  localparam int unsigned ResultWidthDef = 64;
  localparam int unsigned CoefWidth      = 64;
  localparam int unsigned ArgWidth       = 8;
  localparam int unsigned StatusWidth    = 2;

  typedef enum logic [StatusWidth-1:0] {
    StOk       = 2'd0,
    StRange    = 2'd1,
    StOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic done;
    logic ovf;
  } md_stat_t;

endpackage

// File: hdl/bcu_if.sv
// Request and response channel interfaces of the binomial coefficient unit.
interface bcu_req_if import bcu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ArgWidth-1:0] total_n;
  logic [ArgWidth-1:0] choose_k;

  modport source (output valid, total_n, choose_k, input ready);
  modport sink (input valid, total_n, choose_k, output ready);
endinterface

interface bcu_rsp_if import bcu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CoefWidth-1:0]   coefficient;
  logic [StatusWidth-1:0] status;

  modport source (output valid, coefficient, status, input ready);
  modport sink (input valid, coefficient, status, output ready);
endinterface

// File: hdl/binomial_coefficient_unit.sv
// Top level of the binomial coefficient unit with its step sequencer.
//
//   Channel  Direction  Payload
//   req      sink       total_n[7:0], choose_k[7:0]
//   rsp      source     coefficient[63:0], status[1:0]
//
// One transaction on req yields exactly one transaction on rsp.
// With k' = min(k, n-k), a request takes up to k' steps, each of which runs the
// shared multiply-divide unit.
// At the default width overflow ends every request within 33 steps.
// Requests are not taken while one is in progress or its response is stalled.
// Reset is asynchronous and active low and returns the sequencer to idle.
module binomial_coefficient_unit import bcu_pkg::*; #(
  parameter int unsigned RESULT_WIDTH = ResultWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  bcu_req_if.sink   req,
  bcu_rsp_if.source rsp
);

  typedef enum logic [4:0] {
    SqIdle  = 5'b00001,
    SqCheck = 5'b00010,
    SqStep  = 5'b00100,
    SqWait  = 5'b01000,
    SqResp  = 5'b10000
  } sq_state_e;

  sq_state_e               state_q, state_d;
  logic [ArgWidth-1:0]     n_q, n_d;
  logic [ArgWidth-1:0]     k_q, k_d;
  logic [ArgWidth-1:0]     i_q, i_d;
  logic [RESULT_WIDTH-1:0] r_q, r_d;
  logic [CoefWidth-1:0]    coef_q, coef_d;
  status_e                 status_q, status_d;
  logic [ArgWidth-1:0]     n_minus_k;
  logic                    md_start;
  logic [RESULT_WIDTH-1:0] md_quot;
  md_stat_t                md_stat;

  assign n_minus_k = n_q - k_q;
  assign md_start  = (state_q == SqStep) && (i_q != k_q);

  bcu_muldiv #(
    .RESULT_WIDTH(RESULT_WIDTH)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(md_start),
    .value_i(r_q),
    .mul_i  (n_q - i_q),
    .div_i  (i_q + 1'b1),
    .quot_o (md_quot),
    .stat_o (md_stat)
  );

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    k_d      = k_q;
    i_d      = i_q;
    r_d      = r_q;
    coef_d   = coef_q;
    status_d = status_q;
    case (state_q)
      SqIdle: begin
        if (req.valid) begin
          n_d     = req.total_n;
          k_d     = req.choose_k;
          state_d = SqCheck;
        end
      end
      SqCheck: begin
        if (k_q > n_q) begin
          coef_d   = '0;
          status_d = StRange;
          state_d  = SqResp;
        end else begin
          if (k_q > n_minus_k) begin
            k_d = n_minus_k;
          end
          i_d     = '0;
          r_d     = RESULT_WIDTH'(1);
          state_d = SqStep;
        end
      end
      SqStep: begin
        if (i_q == k_q) begin
          coef_d   = CoefWidth'(r_q);
          status_d = StOk;
          state_d  = SqResp;
        end else begin
          state_d = SqWait;
        end
      end
      SqWait: begin
        if (md_stat.done) begin
          if (md_stat.ovf) begin
            coef_d   = '0;
            status_d = StOverflow;
            state_d  = SqResp;
          end else begin
            r_d     = md_quot;
            i_d     = i_q + 1'b1;
            state_d = SqStep;
          end
        end
      end
      SqResp: begin
        if (rsp.ready) begin
          state_d = SqIdle;
        end
      end
      default: begin
        state_d = SqIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    k_q      <= k_d;
    i_q      <= i_d;
    r_q      <= r_d;
    coef_q   <= coef_d;
    status_q <= status_d;
  end

  assign req.ready       = (state_q == SqIdle);
  assign rsp.valid       = (state_q == SqResp);
  assign rsp.coefficient = coef_q;
  assign rsp.status      = status_q;

endmodule

// File: hdl/bcu_muldiv.sv
// Shared multiply and two-bits-per-cycle restoring divide unit for one formula step.
module bcu_muldiv import bcu_pkg::*; #(
  parameter int unsigned RESULT_WIDTH = ResultWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [RESULT_WIDTH-1:0] value_i,
  input  logic [ArgWidth-1:0]     mul_i,
  input  logic [ArgWidth-1:0]     div_i,
  output logic [RESULT_WIDTH-1:0] quot_o,
  output md_stat_t                stat_o
);

  localparam int unsigned ProdWidth = RESULT_WIDTH + ArgWidth;
  localparam int unsigned DvdWidth  = ProdWidth + (ProdWidth % 2);
  localparam int unsigned Steps     = DvdWidth / 2;
  localparam int unsigned CntWidth  = $clog2(Steps);

  typedef enum logic [2:0] {
    MdIdle = 3'b001,
    MdMul  = 3'b010,
    MdDiv  = 3'b100
  } md_state_e;

  md_state_e             state_q, state_d;
  logic                  done_q, done_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [RESULT_WIDTH-1:0] value_q, value_d;
  logic [ArgWidth-1:0]   mul_q, mul_d;
  logic [ArgWidth-1:0]   div_q, div_d;
  logic [DvdWidth-1:0]   dvd_q, dvd_d;
  logic [ArgWidth-1:0]   rem_q, rem_d;
  logic [ProdWidth-1:0]  prod;
  logic [DvdWidth-1:0]   dvd_step;
  logic [ArgWidth-1:0]   rem_step;

  assign prod = ProdWidth'(value_q) * ProdWidth'(mul_q);

  always_comb begin
    logic [ArgWidth:0]   trial;
    logic [ArgWidth-1:0] r;
    logic [DvdWidth-1:0] d;
    r = rem_q;
    d = dvd_q;
    for (int j = 0; j < 2; j++) begin
      trial = {r, d[DvdWidth-1]};
      if (trial >= {1'b0, div_q}) begin
        r = ArgWidth'(trial - {1'b0, div_q});
        d = {d[DvdWidth-2:0], 1'b1};
      end else begin
        r = trial[ArgWidth-1:0];
        d = {d[DvdWidth-2:0], 1'b0};
      end
    end
    rem_step = r;
    dvd_step = d;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    value_d = value_q;
    mul_d   = mul_q;
    div_d   = div_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    case (state_q)
      MdIdle: begin
        if (start_i) begin
          value_d = value_i;
          mul_d   = mul_i;
          div_d   = div_i;
          state_d = MdMul;
        end
      end
      MdMul: begin
        dvd_d   = DvdWidth'(prod);
        rem_d   = '0;
        cnt_d   = CntWidth'(Steps - 1);
        state_d = MdDiv;
      end
      MdDiv: begin
        dvd_d = dvd_step;
        rem_d = rem_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = MdIdle;
        end
      end
      default: begin
        state_d = MdIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MdIdle;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    mul_q   <= mul_d;
    div_q   <= div_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
  end

  assign quot_o      = dvd_q[RESULT_WIDTH-1:0];
  assign stat_o.done = done_q;
  assign stat_o.ovf  = |dvd_q[DvdWidth-1:RESULT_WIDTH];

endmodule

// File: test/tb.sv
// Testbench for the binomial coefficient unit: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import bcu_pkg::*;

  localparam int unsigned ResultW    = ResultWidthDef;
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned HoldCycles = 800;
  localparam int unsigned TailCycles = 5200;
  localparam int unsigned NumRandom  = 112;

  typedef struct packed {
    logic [CoefWidth-1:0] coef;
    status_e              status;
  } binom_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bcu_req_if req_ch ();
  bcu_rsp_if rsp_ch ();

  binomial_coefficient_unit #(
    .RESULT_WIDTH(ResultW)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req   (req_ch),
    .rsp   (rsp_ch)
  );

  binom_t      pending_coefs[$];
  int unsigned cycle_cnt     = 0;
  int unsigned err_cnt       = 0;
  int unsigned n_sent        = 0;
  int unsigned n_req         = 0;
  int unsigned n_rsp         = 0;
  int unsigned n_range       = 0;
  int unsigned n_ovf         = 0;
  int unsigned tx_burst_left = 0;
  bit          tx_bursty     = 1'b1;
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned rx_mode       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic binom_t binom_predict(input logic [ArgWidth-1:0] n,
                                           input logic [ArgWidth-1:0] k);
    binom_t         res;
    logic [7:0]     k_eff;
    logic [79:0]    prod;
    logic [79:0]    quo;
    logic [63:0]    run;
    bit             ovf;
    int unsigned    i;
    res.coef = '0;
    if (k > n) begin
      res.status = StRange;
      return res;
    end
    k_eff = (k > n - k) ? n - k : k;
    run   = 64'd1;
    ovf   = 1'b0;
    for (i = 0; i < k_eff && !ovf; i++) begin
      prod = 80'(run) * (80'(n) - 80'(i));
      quo  = prod / (80'(i) + 80'd1);
      if ((quo >> ResultW) != 80'd0) begin
        ovf = 1'b1;
      end else begin
        run = quo[63:0];
      end
    end
    if (ovf) begin
      res.status = StOverflow;
    end else begin
      res.coef   = run;
      res.status = StOk;
    end
    return res;
  endfunction

  // The receiver switches between random stall patterns; a requested hold-off overrides it.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (cycle_cnt % 256 == 0) begin
      rx_mode = $urandom_range(0, 3);
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: begin
          rsp_ch.ready <= 1'b1;
        end
        1: begin
          rsp_ch.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          rsp_ch.ready <= (cycle_cnt % 7 != 3);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    binom_t want;
    if (rst_n && req_ch.valid && req_ch.ready) begin
      pending_coefs.insert(pending_coefs.size(),
                           binom_predict(req_ch.total_n, req_ch.choose_k));
      n_req++;
    end
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      n_rsp++;
      if (pending_coefs.size() == 0) begin
        $error("unexpected transaction: coefficient %0d status %0d",
               rsp_ch.coefficient, rsp_ch.status);
        err_cnt++;
      end else begin
        want = pending_coefs.pop_front();
        if (want.status == StRange) n_range++;
        if (want.status == StOverflow) n_ovf++;
        if (rsp_ch.coefficient !== want.coef) begin
          $error("coefficient: expected %0d, actual %0d", want.coef, rsp_ch.coefficient);
          err_cnt++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          err_cnt++;
        end
      end
    end
  end

  task automatic send_pair(input logic [ArgWidth-1:0] n, input logic [ArgWidth-1:0] k);
    int unsigned gap;
    if (tx_burst_left == 0) begin
      gap = tx_bursty ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tx_burst_left = $urandom_range(1, 10);
    end
    req_ch.valid    <= 1'b1;
    req_ch.total_n  <= n;
    req_ch.choose_k <= k;
    do @(posedge clk); while (!req_ch.ready);
    tx_burst_left--;
    n_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid  <= 1'b0;
    tx_burst_left = 0;
    do @(posedge clk); while (pending_coefs.size() != 0 || n_req != n_sent);
  endtask

  task automatic send_random();
    logic [ArgWidth-1:0] n;
    logic [ArgWidth-1:0] k;
    int unsigned         sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      n = 8'($urandom_range(0, 67));
      k = 8'($urandom_range(0, n));
    end else if (sel < 60) begin
      n = 8'($urandom_range(0, 255));
      k = 8'($urandom_range(0, (n < 8) ? n : 8));
      if ($urandom_range(0, 1) == 1) k = n - k;
    end else if (sel < 75) begin
      n = 8'($urandom);
      k = 8'($urandom);
    end else if (sel < 85) begin
      n = 8'($urandom_range(0, 254));
      k = 8'($urandom_range(n + 1, 255));
    end else begin
      n = 8'($urandom_range(58, 72));
      k = 8'(n / 2 + $urandom_range(0, 6) - 3);
    end
    send_pair(n, k);
  endtask

  task automatic test_edges();
    send_pair(8'd0, 8'd0);
    send_pair(8'd255, 8'd255);
    send_pair(8'd255, 8'd0);
    send_pair(8'd1, 8'd0);
    send_pair(8'd1, 8'd1);
    send_pair(8'd255, 8'd1);
    send_pair(8'd255, 8'd254);
    send_pair(8'd128, 8'd127);
    send_pair(8'd200, 8'd3);
    send_pair(8'd170, 8'd85);
  endtask

  task automatic test_range();
    send_pair(8'd0, 8'd1);
    send_pair(8'd0, 8'd255);
    send_pair(8'd254, 8'd255);
    send_pair(8'd127, 8'd128);
    send_pair(8'd1, 8'd2);
  endtask

  task automatic test_overflow();
    send_pair(8'd67, 8'd33);
    send_pair(8'd68, 8'd34);
    send_pair(8'd68, 8'd33);
    send_pair(8'd66, 8'd33);
    send_pair(8'd255, 8'd127);
    send_pair(8'd255, 8'd11);
    send_pair(8'd255, 8'd12);
    wait_drained();
  endtask

  // Responses are held off while requests keep coming, so the unit has to stall its input.
  task automatic test_backpressure();
    int unsigned i;
    tx_bursty = 1'b0;
    hold_req  = 1'b1;
    for (i = 0; i < 6; i++) begin
      send_pair(8'($urandom_range(0, 40)), 8'($urandom_range(0, 6)));
    end
    wait_drained();
    tx_bursty = 1'b1;
  endtask

  task automatic test_random();
    int unsigned i;
    for (i = 0; i < NumRandom; i++) begin
      tx_bursty = ((i / 35) % 2 == 0);
      send_random();
      if (i == NumRandom / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.total_n  = '0;
    req_ch.choose_k = '0;
    rsp_ch.ready    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_range();
    test_overflow();
    test_backpressure();
    test_random();
    repeat (TailCycles) @(posedge clk);
    $display("Checked %0d results for %0d requests in %0d cycles.", n_rsp, n_req, cycle_cnt);
    $display("Of these %0d had k above n and %0d overflowed 64 bits.", n_range, n_ovf);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: binomial_coefficient_unit.f
hdl/bcu_pkg.sv
hdl/bcu_if.sv
hdl/bcu_muldiv.sv
hdl/binomial_coefficient_unit.sv
test/tb.sv
